// File: rtl/core/mbe_pkg.sv
// Shared types and constants for the Mandelbrot escape-time unit.
// Holds the controller state type, command/status structs and register codes.
// No dependencies.
`default_nettype none

package mbe_pkg;

   // Fixed field widths and number formats.
   localparam int INT_BITS       = 5;
   localparam int SCALE_BITS     = 28;
   localparam int SCALE_FRAC     = 27;
   localparam int MAG_FRAC       = 26;
   localparam int MAG_BITS       = 32;
   localparam int STEP_BITS      = 16;
   localparam int RSP_DATA_BITS  = 48;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 28;
   localparam int MUL_DIGIT_BITS = 16;

   // Register values after reset.
   localparam int RST_BASE_ROW  = 400;
   localparam int RST_BASE_COL  = 800;
   localparam int RST_ROW_SCALE = 335544;
   localparam int RST_COL_SCALE = 335544;
   localparam int RST_MAX_ITER  = 16000;

   // Configuration register indexes.
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_BASE_ROW  = 3'd0,
      CSR_BASE_COL  = 3'd1,
      CSR_ROW_SCALE = 3'd2,
      CSR_COL_SCALE = 3'd3,
      CSR_MAX_ITER  = 3'd4
   } csr_index_type;

   // Controller states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CMUL_RE,
      ST_CMUL_IM,
      ST_CCONV_IM,
      ST_ITER,
      ST_MWAIT,
      ST_TEST,
      ST_DONE
   } ctrl_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic coord_mul;
      logic coord_imag;
      logic store_cr;
      logic store_ci;
      logic init_z;
      logic iter;
      logic step_inc;
      logic load_out;
      logic out_escaped;
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic mul_done;
      logic escape;
      logic last_step;
      logic limit_zero;
      logic out_free;
   } dp_status_type;

endpackage

`default_nettype wire

// File: rtl/core/mandelbrot_escape_time_unit.sv
// Top level of the Mandelbrot escape-time unit: configuration registers,
// stream packing, controller and datapath. Depends on mbe_pkg, mbe_ctrl, mbe_datapath.
//
// Channel   Dir  Handshake                 Payload
// req_*     in   req_tvalid / req_tready   tdata: pixel_row, pixel_col
// rsp_*     out  rsp_tvalid / rsp_tready   tdata: escape_step, magnitude_sq; tuser: escaped
// csr_*     in   csr_valid / csr_ready     csr_index, csr_data
//
// An item runs N iterations, N being at most max_iterations, and the z multipliers
// take D = ceil((FRACTION_BITS + 5) / 16) digit steps per product.
// Reset is synchronous and active high; it loads the default register values.
// A new pixel is taken while the previous result beat waits in the output
// register; the finished result then waits for that register to drain.
`default_nettype none

module mandelbrot_escape_time_unit #(
   parameter int COORD_BITS    = 12,
   parameter int FRACTION_BITS = 27
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   // tdata: pixel_row, pixel_col, zero padding
   input  wire logic                                   req_tvalid,
   output logic                                        req_tready,
   input  wire logic [((2*COORD_BITS+7)/8)*8-1:0]      req_tdata,
   // tdata: escape_step [15:0], magnitude_sq [47:16]
   // tuser: escaped
   output logic                                        rsp_tvalid,
   input  wire logic                                   rsp_tready,
   output logic [mbe_pkg::RSP_DATA_BITS-1:0]           rsp_tdata,
   output logic                                        rsp_tuser,
   input  wire logic                                   csr_valid,
   output logic                                        csr_ready,
   input  wire logic [mbe_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  wire logic [mbe_pkg::CSR_DATA_BITS-1:0]      csr_data
);

   logic [COORD_BITS-1:0]          base_row_ff;
   logic [COORD_BITS-1:0]          base_col_ff;
   logic [mbe_pkg::SCALE_BITS-1:0] row_scale_ff;
   logic [mbe_pkg::SCALE_BITS-1:0] col_scale_ff;
   logic [mbe_pkg::STEP_BITS-1:0]  max_iter_ff;

   mbe_pkg::dp_cmd_type            cmd;
   mbe_pkg::dp_status_type         status;
   logic                           rsp_escaped;
   logic [mbe_pkg::STEP_BITS-1:0]  rsp_escape_step;
   logic [mbe_pkg::MAG_BITS-1:0]   rsp_magnitude_sq;

   // Configuration writes are always taken.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_row_ff  <= COORD_BITS'(mbe_pkg::RST_BASE_ROW);
         base_col_ff  <= COORD_BITS'(mbe_pkg::RST_BASE_COL);
         row_scale_ff <= mbe_pkg::SCALE_BITS'(mbe_pkg::RST_ROW_SCALE);
         col_scale_ff <= mbe_pkg::SCALE_BITS'(mbe_pkg::RST_COL_SCALE);
         max_iter_ff  <= mbe_pkg::STEP_BITS'(mbe_pkg::RST_MAX_ITER);
      end else if (csr_valid) begin
         unique case (mbe_pkg::csr_index_type'(csr_index))
            mbe_pkg::CSR_BASE_ROW:  base_row_ff  <= csr_data[COORD_BITS-1:0];
            mbe_pkg::CSR_BASE_COL:  base_col_ff  <= csr_data[COORD_BITS-1:0];
            mbe_pkg::CSR_ROW_SCALE: row_scale_ff <= csr_data[mbe_pkg::SCALE_BITS-1:0];
            mbe_pkg::CSR_COL_SCALE: col_scale_ff <= csr_data[mbe_pkg::SCALE_BITS-1:0];
            mbe_pkg::CSR_MAX_ITER:  max_iter_ff  <= csr_data[mbe_pkg::STEP_BITS-1:0];
            default: ;
         endcase
      end
   end

   // Sequencing of one pixel.
   mbe_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // Arithmetic and the result register.
   mbe_datapath #(
      .COORD_BITS    (COORD_BITS),
      .FRACTION_BITS (FRACTION_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .pixel_row        (req_tdata[COORD_BITS-1:0]),
      .pixel_col        (req_tdata[2*COORD_BITS-1:COORD_BITS]),
      .base_row         (base_row_ff),
      .base_col         (base_col_ff),
      .row_scale        (row_scale_ff),
      .col_scale        (col_scale_ff),
      .max_iterations   (max_iter_ff),
      .rsp_tready       (rsp_tready),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_escaped      (rsp_escaped),
      .rsp_escape_step  (rsp_escape_step),
      .rsp_magnitude_sq (rsp_magnitude_sq)
   );

   // Result beat packing.
   assign rsp_tdata = {rsp_magnitude_sq, rsp_escape_step};
   assign rsp_tuser = rsp_escaped;

endmodule

`default_nettype wire

// File: rtl/core/mbe_mul.sv
// Signed fixed-point multiplier, floor(a * b / 2^F), one 16-bit digit per cycle.
// Takes an operand pair on start and raises done for one cycle with the product.
// Depends on mbe_pkg.
`default_nettype none

module mbe_mul #(
   parameter int FRACTION_BITS = 27
) (
   input  wire logic                                               clock,
   input  wire logic                                               reset,
   input  wire logic                                               start,
   input  wire logic signed [FRACTION_BITS+mbe_pkg::INT_BITS-1:0]  op_a,
   input  wire logic signed [FRACTION_BITS+mbe_pkg::INT_BITS-1:0]  op_b,
   output logic                                                    done,
   output logic signed [FRACTION_BITS+2*mbe_pkg::INT_BITS-1:0]     product
);

   localparam int ZW   = FRACTION_BITS + mbe_pkg::INT_BITS;
   localparam int PW   = FRACTION_BITS + 2 * mbe_pkg::INT_BITS;
   localparam int DIG  = mbe_pkg::MUL_DIGIT_BITS;
   localparam int NDIG = (ZW + DIG - 1) / DIG;
   localparam int BW   = NDIG * DIG;
   localparam int AW   = ZW + BW;
   localparam int CW   = (NDIG > 1) ? $clog2(NDIG) : 1;

   logic          busy_ff, busy_in;
   logic          fin_ff, fin_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          neg_ff;
   logic [ZW-1:0] ua_ff;
   logic [BW-1:0] ub_ff;
   logic [AW-1:0] acc_ff;

   logic [ZW-1:0]     mag_a;
   logic [ZW-1:0]     mag_b;
   logic [ZW+DIG-1:0] partial;
   logic [AW-1:0]     acc_next;
   logic [PW-1:0]     quot;
   logic [PW-1:0]     quot_rd;
   logic              rem_nz;

   // Operand magnitudes; the most negative value maps to its exact magnitude.
   always_comb begin
      mag_a = op_a[ZW-1] ? (~op_a + ZW'(1)) : op_a;
      mag_b = op_b[ZW-1] ? (~op_b + ZW'(1)) : op_b;
   end

   // One digit of the second operand per cycle, most significant digit first.
   always_comb begin
      partial  = ua_ff * ub_ff[BW-1 -: DIG];
      acc_next = {acc_ff[AW-DIG-1:0], {DIG{1'b0}}} + AW'(partial);
   end

   // Sequencing of the digit steps.
   always_comb begin
      busy_in = busy_ff;
      fin_in  = 1'b0;
      cnt_in  = cnt_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(NDIG - 1);
      end else if (busy_ff) begin
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            fin_in  = 1'b1;
         end else begin
            cnt_in = cnt_ff - CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff  <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         fin_ff  <= fin_in;
         cnt_ff  <= cnt_in;
      end
   end

   // Operand and accumulator registers.
   always_ff @(posedge clock) begin
      if (start) begin
         neg_ff <= op_a[ZW-1] ^ op_b[ZW-1];
         ua_ff  <= mag_a;
         ub_ff  <= BW'(mag_b);
         acc_ff <= '0;
      end else if (busy_ff) begin
         ub_ff  <= ub_ff << DIG;
         acc_ff <= acc_next;
      end
   end

   // Scale down by 2^F, rounding toward minus infinity for negative products.
   always_comb begin
      quot    = acc_ff[FRACTION_BITS +: PW];
      rem_nz  = |acc_ff[FRACTION_BITS-1:0];
      quot_rd = quot + PW'(rem_nz);
      product = neg_ff ? $signed(-quot_rd) : $signed(quot);
      done    = fin_ff;
   end

endmodule

`default_nettype wire

// File: rtl/core/mbe_ctrl.sv
// Controller state machine for the Mandelbrot escape-time unit.
// Issues datapath commands and reads datapath status; depends on mbe_pkg.
`default_nettype none

module mbe_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire mbe_pkg::dp_status_type status,
   output mbe_pkg::dp_cmd_type         cmd
);

   mbe_pkg::ctrl_state_type state_ff, state_in;
   logic                    esc_ff, esc_in;

   // State and escape flag registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mbe_pkg::ST_IDLE;
         esc_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         esc_ff   <= esc_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in   = state_ff;
      esc_in     = esc_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         mbe_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = mbe_pkg::ST_CMUL_RE;
            end
         end
         mbe_pkg::ST_CMUL_RE: begin
            cmd.coord_mul = 1'b1;
            state_in      = mbe_pkg::ST_CMUL_IM;
         end
         mbe_pkg::ST_CMUL_IM: begin
            cmd.coord_mul  = 1'b1;
            cmd.coord_imag = 1'b1;
            cmd.store_cr   = 1'b1;
            state_in       = mbe_pkg::ST_CCONV_IM;
         end
         mbe_pkg::ST_CCONV_IM: begin
            cmd.store_ci = 1'b1;
            cmd.init_z   = 1'b1;
            if (status.limit_zero) begin
               esc_in   = 1'b0;
               state_in = mbe_pkg::ST_DONE;
            end else begin
               state_in = mbe_pkg::ST_ITER;
            end
         end
         mbe_pkg::ST_ITER: begin
            cmd.iter = 1'b1;
            state_in = mbe_pkg::ST_MWAIT;
         end
         mbe_pkg::ST_MWAIT: begin
            if (status.mul_done) begin
               state_in = mbe_pkg::ST_TEST;
            end
         end
         mbe_pkg::ST_TEST: begin
            priority if (status.escape) begin
               esc_in   = 1'b1;
               state_in = mbe_pkg::ST_DONE;
            end else if (status.last_step) begin
               esc_in   = 1'b0;
               state_in = mbe_pkg::ST_DONE;
            end else begin
               cmd.step_inc = 1'b1;
               state_in     = mbe_pkg::ST_ITER;
            end
         end
         mbe_pkg::ST_DONE: begin
            if (status.out_free) begin
               cmd.load_out    = 1'b1;
               cmd.out_escaped = esc_ff;
               state_in        = mbe_pkg::ST_IDLE;
            end
         end
      endcase
   end

endmodule

`default_nettype wire

// File: rtl/core/mbe_datapath.sv
// Datapath for the Mandelbrot escape-time unit: pixel to c mapping, z update,
// three digit-serial multipliers, escape test and result register.
// Depends on mbe_pkg and mbe_mul.
`default_nettype none

module mbe_datapath #(
   parameter int COORD_BITS    = 12,
   parameter int FRACTION_BITS = 27
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire mbe_pkg::dp_cmd_type                  cmd,
   output mbe_pkg::dp_status_type                    status,
   input  wire logic [COORD_BITS-1:0]                pixel_row,
   input  wire logic [COORD_BITS-1:0]                pixel_col,
   input  wire logic [COORD_BITS-1:0]                base_row,
   input  wire logic [COORD_BITS-1:0]                base_col,
   input  wire logic [mbe_pkg::SCALE_BITS-1:0]       row_scale,
   input  wire logic [mbe_pkg::SCALE_BITS-1:0]       col_scale,
   input  wire logic [mbe_pkg::STEP_BITS-1:0]        max_iterations,
   input  wire logic                                 rsp_tready,
   output logic                                      rsp_tvalid,
   output logic                                      rsp_escaped,
   output logic [mbe_pkg::STEP_BITS-1:0]             rsp_escape_step,
   output logic [mbe_pkg::MAG_BITS-1:0]              rsp_magnitude_sq
);

   localparam int ZW  = FRACTION_BITS + mbe_pkg::INT_BITS;
   localparam int PW  = FRACTION_BITS + 2 * mbe_pkg::INT_BITS;
   localparam int SW  = PW + 2;
   localparam int PRW = COORD_BITS + mbe_pkg::SCALE_BITS;
   localparam int SCL = (FRACTION_BITS >= mbe_pkg::SCALE_FRAC) ?
                        FRACTION_BITS - mbe_pkg::SCALE_FRAC : 0;
   localparam int SCR = (FRACTION_BITS < mbe_pkg::SCALE_FRAC) ?
                        mbe_pkg::SCALE_FRAC - FRACTION_BITS : 0;
   localparam int MGW = PRW + SCL + 1;
   localparam int SHL = (FRACTION_BITS < mbe_pkg::MAG_FRAC) ?
                        mbe_pkg::MAG_FRAC - FRACTION_BITS : 0;
   localparam int SHR = (FRACTION_BITS >= mbe_pkg::MAG_FRAC) ?
                        FRACTION_BITS - mbe_pkg::MAG_FRAC : 0;
   localparam int EW  = PW + 1 + SHL;
   localparam int MB  = mbe_pkg::MAG_BITS;

   localparam logic signed [ZW-1:0] ZMAX_Z = {1'b0, {(ZW-1){1'b1}}};
   localparam logic signed [ZW-1:0] ZMIN_Z = {1'b1, {(ZW-1){1'b0}}};
   localparam logic signed [SW-1:0] ZMAX_S = {{(SW-ZW+1){1'b0}}, {(ZW-1){1'b1}}};
   localparam logic signed [SW-1:0] ZMIN_S = {{(SW-ZW+1){1'b1}}, {(ZW-1){1'b0}}};
   localparam logic [PW:0]          LIMIT  =
      {{(PW-FRACTION_BITS-2){1'b0}}, 1'b1, {(FRACTION_BITS+2){1'b0}}};

   logic [COORD_BITS-1:0]             row_ff, col_ff;
   logic [PRW-1:0]                    prod_ff, prod_in;
   logic                              cneg_ff, cneg_in;
   logic signed [ZW-1:0]              cr_ff, ci_ff;
   logic signed [PW-1:0]              rr_ff, ii_ff, ri_ff;
   logic [mbe_pkg::STEP_BITS-1:0]     step_ff;
   logic                              out_valid_ff;
   logic                              out_esc_ff;
   logic [mbe_pkg::STEP_BITS-1:0]     out_step_ff;
   logic [MB-1:0]                     out_mag_ff;

   logic [COORD_BITS-1:0]          p_sel, b_sel, diff;
   logic [mbe_pkg::SCALE_BITS-1:0] scale_sel;
   logic [MGW-1:0]                 mag_sh, mag_rnd, mag_rd;
   logic                           pos_ovf, neg_ovf;
   logic signed [ZW-1:0]           c_conv;
   logic signed [SW-1:0]           sr_sum, si_sum;
   logic signed [ZW-1:0]           zr_next, zi_next;
   logic signed [PW-1:0]           rr_prod, ii_prod, ri_prod;
   logic                           rr_done, ii_done, ri_done;
   logic [PW:0]                    msq;
   logic [EW-1:0]                  mext;
   logic [MB-1:0]                  mag32;

   // Coordinate offset times the per-pixel step.
   always_comb begin
      p_sel     = cmd.coord_imag ? base_row : col_ff;
      b_sel     = cmd.coord_imag ? row_ff : base_col;
      scale_sel = cmd.coord_imag ? row_scale : col_scale;
      cneg_in   = p_sel < b_sel;
      diff      = cneg_in ? (b_sel - p_sel) : (p_sel - b_sel);
      prod_in   = PRW'(diff) * PRW'(scale_sel);
   end

   // Align the registered product to F fraction bits and saturate to Q5.F.
   always_comb begin
      mag_sh  = MGW'(prod_ff) << SCL;
      mag_rnd = cneg_ff ? MGW'((1 << SCR) - 1) : '0;
      mag_rd  = (mag_sh + mag_rnd) >> SCR;
      pos_ovf = |mag_rd[MGW-1:ZW-1];
      neg_ovf = pos_ovf && ((|mag_rd[ZW-2:0]) || (|mag_rd[MGW-1:ZW]));
      if (cneg_ff) begin
         c_conv = neg_ovf ? ZMIN_Z : $signed(-mag_rd[ZW-1:0]);
      end else begin
         c_conv = pos_ovf ? ZMAX_Z : $signed(mag_rd[ZW-1:0]);
      end
   end

   // Next z from the squares and cross product of the current z, saturated.
   always_comb begin
      sr_sum = $signed({{2{rr_ff[PW-1]}}, rr_ff}) - $signed({{2{ii_ff[PW-1]}}, ii_ff})
             + $signed({{(SW-ZW){cr_ff[ZW-1]}}, cr_ff});
      si_sum = $signed({ri_ff[PW-1], ri_ff, 1'b0})
             + $signed({{(SW-ZW){ci_ff[ZW-1]}}, ci_ff});
      if (sr_sum > ZMAX_S) begin
         zr_next = ZMAX_Z;
      end else if (sr_sum < ZMIN_S) begin
         zr_next = ZMIN_Z;
      end else begin
         zr_next = $signed(sr_sum[ZW-1:0]);
      end
      if (si_sum > ZMAX_S) begin
         zi_next = ZMAX_Z;
      end else if (si_sum < ZMIN_S) begin
         zi_next = ZMIN_Z;
      end else begin
         zi_next = $signed(si_sum[ZW-1:0]);
      end
   end

   // The squares of the new z serve both the escape test and the next update.
   mbe_mul #(.FRACTION_BITS(FRACTION_BITS)) u_mul_rr (
      .clock   (clock),
      .reset   (reset),
      .start   (cmd.iter),
      .op_a    (zr_next),
      .op_b    (zr_next),
      .done    (rr_done),
      .product (rr_prod)
   );

   mbe_mul #(.FRACTION_BITS(FRACTION_BITS)) u_mul_ii (
      .clock   (clock),
      .reset   (reset),
      .start   (cmd.iter),
      .op_a    (zi_next),
      .op_b    (zi_next),
      .done    (ii_done),
      .product (ii_prod)
   );

   mbe_mul #(.FRACTION_BITS(FRACTION_BITS)) u_mul_ri (
      .clock   (clock),
      .reset   (reset),
      .start   (cmd.iter),
      .op_a    (zr_next),
      .op_b    (zi_next),
      .done    (ri_done),
      .product (ri_prod)
   );

   // Pixel, c, product and step registers.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         row_ff <= pixel_row;
         col_ff <= pixel_col;
      end
      if (cmd.coord_mul) begin
         prod_ff <= prod_in;
         cneg_ff <= cneg_in;
      end
      if (cmd.store_cr) begin
         cr_ff <= c_conv;
      end
      if (cmd.store_ci) begin
         ci_ff <= c_conv;
      end
      if (cmd.init_z) begin
         rr_ff   <= '0;
         ii_ff   <= '0;
         ri_ff   <= '0;
         step_ff <= '0;
      end else begin
         if (status.mul_done) begin
            rr_ff <= rr_prod;
            ii_ff <= ii_prod;
            ri_ff <= ri_prod;
         end
         if (cmd.step_inc) begin
            step_ff <= step_ff + 1'b1;
         end
      end
   end

   // Magnitude squared of the new z, rescaled to Q6.26 and saturated.
   always_comb begin
      msq   = {1'b0, rr_ff} + {1'b0, ii_ff};
      mext  = (EW'(msq) << SHL) >> SHR;
      mag32 = (|mext[EW-1:MB]) ? {MB{1'b1}} : mext[MB-1:0];
   end

   // Status toward the controller.
   always_comb begin
      status.mul_done   = rr_done & ii_done & ri_done;
      status.escape     = msq > LIMIT;
      status.last_step  = step_ff == (max_iterations - 1'b1);
      status.limit_zero = max_iterations == '0;
      status.out_free   = !out_valid_ff || rsp_tready;
   end

   // Result register: holds a beat until the consumer takes it.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         out_esc_ff  <= cmd.out_escaped;
         out_step_ff <= cmd.out_escaped ? step_ff : '0;
         out_mag_ff  <= cmd.out_escaped ? mag32 : '0;
      end
   end

   // Result beat outputs.
   always_comb begin
      rsp_tvalid       = out_valid_ff;
      rsp_escaped      = out_esc_ff;
      rsp_escape_step  = out_step_ff;
      rsp_magnitude_sq = out_mag_ff;
   end

endmodule

`default_nettype wire
